@@ hdl/keyframe_timeline_sequencer_top_assert.svh @@
// Assertion macros for the keyframe timeline sequencer.
// Each macro expects clk_i and rst_ni in the scope of the including module.
`ifndef KEYFRAME_TIMELINE_SEQUENCER_TOP_ASSERT_SVH
`define KEYFRAME_TIMELINE_SEQUENCER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define KTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define KTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KTS_ASSERT_IMP(lbl, ante, cons, msg)
`define KTS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ hdl/kts_pkg.sv @@
// Shared types, constants and helpers for the keyframe timeline sequencer.
// No dependencies; the modules import this package and kts_if refers to its widths.
`timescale 1ns / 1ps

package kts_pkg;

  // track limits and fixed point format
  localparam int MaxFrames = 1024;
  localparam int FracBits  = 16;

  // field widths
  localparam int CountW = 11;
  localparam int FpsW   = 16;
  localparam int ModeW  = 2;
  localparam int RateW  = 16;
  localparam int FuncW  = 2;
  localparam int DtW    = 24;
  localparam int SeekW  = 27;
  localparam int FrameW = 10;
  localparam int BlendW = 16;
  localparam int PheadW = 27;

  // step arithmetic: dt * fps * |rate| lands in 2^-40 frame units
  localparam int ProdW     = DtW + FpsW + RateW;
  localparam int StepShift = 40 - FracBits;
  localparam int StepW     = ProdW - StepShift;
  localparam int SumW      = StepW + 1;
  localparam int MulAW     = DtW + FpsW;
  localparam int MulBW     = (FpsW > RateW) ? FpsW : RateW;
  localparam int MulCntW   = $clog2(MulBW + 1);

  // wrap span is up to twice the frame count
  localparam int SpanW   = $clog2(2 * MaxFrames) + 1;
  localparam int ModW    = SpanW + FracBits;
  localparam int RemCntW = $clog2(StepW + 1);

  // configuration port
  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 32;
  localparam int CfgIdxW  = 2;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegFrameCount = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFps        = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPlayMode   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegRate       = 2'd3;

  // register reset values
  localparam logic [CountW-1:0] RstFrameCount = 11'd1;
  localparam logic [FpsW-1:0]   RstFps        = 16'd7680;
  localparam logic [ModeW-1:0]  RstPlayMode   = 2'd0;
  localparam logic [RateW-1:0]  RstRate       = 16'd4096;

  // play modes; the spare code plays as loop
  localparam logic [ModeW-1:0] ModeLoop   = 2'd0;
  localparam logic [ModeW-1:0] ModeSingle = 2'd1;
  localparam logic [ModeW-1:0] ModeMirror = 2'd2;

  typedef enum logic [FuncW-1:0] {
    FuncTick  = 2'd0,
    FuncPlay  = 2'd1,
    FuncPause = 2'd2,
    FuncSeek  = 2'd3
  } func_e;

  typedef struct packed {
    logic [CountW-1:0] frame_count;
    logic [FpsW-1:0]   fps;
    logic [ModeW-1:0]  play_mode;
    logic [RateW-1:0]  rate;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [MulAW-1:0] a;
    logic [MulBW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [StepW-1:0] dividend;
    logic [ModW-1:0]  modulus;
  } rem_req_t;

  // frame count clamped to 1..MaxFrames
  function automatic logic [CountW-1:0] eff_count(input logic [CountW-1:0] c);
    logic [CountW-1:0] r;
    r = c;
    if (r == '0) r = CountW'(1);
    if (int'(r) > MaxFrames) r = CountW'(MaxFrames);
    return r;
  endfunction

  // fraction rescaled to Q0.16
  localparam int ShDn = (FracBits >= BlendW) ? FracBits - BlendW : 0;
  localparam int ShUp = (FracBits < BlendW) ? BlendW - FracBits : 0;

  function automatic logic [BlendW-1:0] to_q16(input logic [FracBits-1:0] f);
    logic [FracBits+BlendW-1:0] ext;
    ext = (FracBits + BlendW)'(f);
    return BlendW'((ext << ShUp) >> ShDn);
  endfunction

endpackage

@@ hdl/kts_if.sv @@
// Valid/ready channel interfaces for command input and frame result output.
// Depends on kts_pkg for field widths.
`timescale 1ns / 1ps

interface kts_in_if;
  logic                         valid;
  logic                         ready;
  logic [kts_pkg::FuncW-1:0]    func;
  logic [kts_pkg::DtW-1:0]      delta_time;
  logic [kts_pkg::SeekW-1:0]    seek_position;

  modport source (output valid, func, delta_time, seek_position, input ready);
  modport sink   (input valid, func, delta_time, seek_position, output ready);
endinterface

interface kts_out_if;
  logic                         valid;
  logic                         ready;
  logic [kts_pkg::FrameW-1:0]   frame_a;
  logic [kts_pkg::FrameW-1:0]   frame_b;
  logic [kts_pkg::BlendW-1:0]   blend_t;
  logic                         ended;
  logic                         is_playing;

  modport source (output valid, frame_a, frame_b, blend_t, ended, is_playing, input ready);
  modport sink   (input valid, frame_a, frame_b, blend_t, ended, is_playing, output ready);
endinterface

@@ hdl/kts_cfg.sv @@
// APB-style configuration registers of the keyframe timeline sequencer.
// Depends on kts_pkg.
`timescale 1ns / 1ps

module kts_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kts_pkg::CfgAddrW-1:0]  paddr,
  input  logic [kts_pkg::CfgDataW-1:0]  pwdata,
  output logic [kts_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  output kts_pkg::cfg_t                 cfg_o
);
  import kts_pkg::*;

  cfg_t               cfg_q, cfg_d;
  logic [CfgIdxW-1:0] idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[CfgAddrW-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  // write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegFrameCount: cfg_d.frame_count = pwdata[CountW-1:0];
        RegFps:        cfg_d.fps         = pwdata[FpsW-1:0];
        RegPlayMode:   cfg_d.play_mode   = pwdata[ModeW-1:0];
        RegRate:       cfg_d.rate        = pwdata[RateW-1:0];
        default:       cfg_d             = cfg_q;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      RegFrameCount: prdata = CfgDataW'(cfg_q.frame_count);
      RegFps:        prdata = CfgDataW'(cfg_q.fps);
      RegPlayMode:   prdata = CfgDataW'(cfg_q.play_mode);
      RegRate:       prdata = CfgDataW'(cfg_q.rate);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_count <= RstFrameCount;
      cfg_q.fps         <= RstFps;
      cfg_q.play_mode   <= RstPlayMode;
      cfg_q.rate        <= RstRate;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/kts_serial_mul.sv @@
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on kts_pkg; done_o rises together with the final product from the last step.
`timescale 1ns / 1ps

module kts_serial_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  kts_pkg::mul_req_t           req_i,
  output logic                        done_o,
  output logic [kts_pkg::ProdW-1:0]   prod_o
);
  import kts_pkg::*;

  logic [ProdW-1:0]   a_q, a_d;
  logic [MulBW-1:0]   b_q, b_d;
  logic [ProdW-1:0]   p_q, p_d;
  logic [MulCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;

  // one partial product per cycle, multiplier consumed LSB first
  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    p_d    = p_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      a_d    = ProdW'(req_i.a);
      b_d    = req_i.b;
      p_d    = '0;
      cnt_d  = MulCntW'(MulBW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q[0]) p_d = p_q + a_q;
      a_d   = a_q << 1;
      b_d   = b_q >> 1;
      cnt_d = cnt_q - MulCntW'(1);
      if (cnt_q == MulCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    p_q <= p_d;
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

@@ hdl/kts_serial_rem.sv @@
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on kts_pkg; done_o rises together with the remainder from the last step.
`timescale 1ns / 1ps

module kts_serial_rem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  kts_pkg::rem_req_t           req_i,
  output logic                        done_o,
  output logic [kts_pkg::ModW-1:0]    rem_o
);
  import kts_pkg::*;

  logic [StepW-1:0]   d_q, d_d;
  logic [ModW-1:0]    m_q, m_d;
  logic [ModW-1:0]    r_q, r_d;
  logic [ModW:0]      trial;
  logic [RemCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;

  // shift in the next dividend bit, subtract the modulus if it fits
  assign trial = {r_q, d_q[StepW-1]};

  always_comb begin
    d_d    = d_q;
    m_d    = m_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      d_d    = req_i.dividend;
      m_d    = req_i.modulus;
      r_d    = '0;
      cnt_d  = RemCntW'(StepW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, m_q}) r_d = ModW'(trial - {1'b0, m_q});
      else                      r_d = ModW'(trial);
      d_d   = d_q << 1;
      cnt_d = cnt_q - RemCntW'(1);
      if (cnt_q == RemCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q <= d_d;
    m_q <= m_d;
    r_q <= r_d;
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule

@@ hdl/keyframe_timeline_sequencer_top.sv @@
// Keyframe timeline sequencer: one command in, one frame result out; one item at a time.
// In single mode a result passes StNorm and StFmt to the output register; loop or
// mirror mode adds StMod (32-step serial remainder); a playing tick first runs StMul1
// and StMul2 for two 16-step serial multiplier passes, then the boundary step StStep.
// A new command is taken only in StIdle; a stalled output holds the item in StFmt.
// Reset (async, active low) loads register defaults, playhead 0 and paused.
`timescale 1ns / 1ps
`include "keyframe_timeline_sequencer_top_assert.svh"

module keyframe_timeline_sequencer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kts_pkg::CfgAddrW-1:0]  paddr,
  input  logic [kts_pkg::CfgDataW-1:0]  pwdata,
  output logic [kts_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  kts_in_if.sink                        in_i,
  kts_out_if.source                     out_o
);
  import kts_pkg::*;

  // sequencer states
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul1 = 3'd1;
  localparam logic [2:0] StMul2 = 3'd2;
  localparam logic [2:0] StStep = 3'd3;
  localparam logic [2:0] StNorm = 3'd4;
  localparam logic [2:0] StMod  = 3'd5;
  localparam logic [2:0] StFmt  = 3'd6;

  cfg_t cfg;

  kts_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic [2:0]              state_q, state_d;
  logic signed [SumW-1:0]  pos_q, pos_d;
  logic                    neg_q, neg_d;
  logic                    flag_q, flag_d;
  logic                    ended_q, ended_d;
  logic [PheadW-1:0]       playhead_q, playhead_d;

  logic                    out_valid_q, out_valid_d;
  logic [FrameW-1:0]       frame_a_q, frame_a_d;
  logic [FrameW-1:0]       frame_b_q, frame_b_d;
  logic [BlendW-1:0]       blend_q, blend_d;
  logic                    oended_q, oended_d;
  logic                    oplay_q, oplay_d;

  mul_req_t                mul_req;
  logic                    mul_done;
  logic [ProdW-1:0]        mul_prod;
  rem_req_t                rem_req;
  logic                    rem_done;
  logic [ModW-1:0]         rem_val;

  kts_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  kts_serial_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .done_o (rem_done),
    .rem_o  (rem_val)
  );

  // configuration-derived values; user-kept stable while an item is in flight, unchecked
  logic [CountW-1:0]       count;
  logic [SpanW-1:0]        count_x;
  logic [SpanW-1:0]        span;
  logic [ModW-1:0]         modulus;
  logic signed [SumW-1:0]  end_pos;
  logic                    single;
  logic                    mirror;
  logic                    rate_neg;
  logic [RateW-1:0]        rate_mag;

  assign count    = eff_count(cfg.frame_count);
  assign count_x  = SpanW'(count);
  assign single   = (cfg.play_mode == ModeSingle);
  assign mirror   = (cfg.play_mode == ModeMirror);
  assign span     = mirror ? (count_x << 1) : count_x;
  assign modulus  = {span, {FracBits{1'b0}}};
  assign end_pos  = $signed(SumW'({count_x - SpanW'(1), {FracBits{1'b0}}}));
  assign rate_neg = cfg.rate[RateW-1];
  assign rate_mag = rate_neg ? (~cfg.rate + RateW'(1)) : cfg.rate;

  logic             in_fire;
  logic             out_free;
  logic [StepW-1:0] step;
  logic [StepW-1:0] pos_mag;

  assign in_i.ready = (state_q == StIdle);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign step       = mul_prod[ProdW-1:StepShift];
  assign pos_mag    = pos_q[SumW-1] ? StepW'(-pos_q) : StepW'(pos_q);

  // frame index and fraction of the normalized playhead
  logic [SpanW-1:0]    whole;
  logic [FracBits-1:0] frac;
  logic [SpanW-1:0]    last;
  logic [SpanW-1:0]    next_w;
  logic [SpanW-1:0]    sa, sb;
  logic [SpanW-1:0]    la, lb;
  logic [SpanW-1:0]    fa, fb;
  logic [FracBits-1:0] fr;

  assign whole  = pos_q[FracBits +: SpanW];
  assign frac   = pos_q[FracBits-1:0];
  assign last   = count_x - SpanW'(1);
  assign next_w = whole + SpanW'(1);

  always_comb begin
    // single shot: clamp next index at the last frame
    sa = whole;
    sb = (whole < last) ? next_w : last;
    // loop and mirror: wrap next index at the span, then fold for mirror
    la = whole;
    lb = (next_w == span) ? '0 : next_w;
    if (mirror && la >= count_x) la = (count_x << 1) - SpanW'(1) - la;
    if (mirror && lb >= count_x) lb = (count_x << 1) - SpanW'(1) - lb;
    if (single) begin
      fa = sa;
      fb = sb;
      fr = (sa == sb) ? '0 : frac;
    end else begin
      fa = la;
      fb = lb;
      fr = frac;
    end
  end

  // item sequencer
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    neg_d       = neg_q;
    flag_d      = flag_q;
    ended_d     = ended_q;
    playhead_d  = playhead_q;
    out_valid_d = out_valid_q && !out_o.ready;
    frame_a_d   = frame_a_q;
    frame_b_d   = frame_b_q;
    blend_d     = blend_q;
    oended_d    = oended_q;
    oplay_d     = oplay_q;
    mul_req     = '0;
    rem_req     = '0;
    rem_req.modulus = modulus;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          ended_d = 1'b0;
          pos_d   = $signed(SumW'(playhead_q));
          state_d = StNorm;
          unique case (func_e'(in_i.func))
            FuncPlay:  flag_d = 1'b1;
            FuncPause: flag_d = 1'b0;
            FuncSeek:  pos_d  = $signed(SumW'(in_i.seek_position));
            FuncTick: begin
              if (flag_q) begin
                mul_req.start = 1'b1;
                mul_req.a     = MulAW'(in_i.delta_time);
                mul_req.b     = MulBW'(cfg.fps);
                state_d       = StMul1;
              end
            end
            default: state_d = StNorm;
          endcase
        end
      end
      StMul1: begin
        // second pass: (dt * fps) * |rate|
        if (mul_done) begin
          mul_req.start = 1'b1;
          mul_req.a     = mul_prod[MulAW-1:0];
          mul_req.b     = MulBW'(rate_mag);
          state_d       = StMul2;
        end
      end
      StMul2: begin
        if (mul_done) begin
          if (rate_neg) pos_d = pos_q - $signed({1'b0, step});
          else          pos_d = pos_q + $signed({1'b0, step});
          state_d = StStep;
        end
      end
      StStep: begin
        // single shot boundary stops playback
        if (single && (pos_q < 0 || pos_q > end_pos)) begin
          pos_d   = rate_neg ? '0 : end_pos;
          flag_d  = 1'b0;
          ended_d = 1'b1;
        end
        state_d = StNorm;
      end
      StNorm: begin
        if (single) begin
          if (pos_q < 0)            pos_d = '0;
          else if (pos_q > end_pos) pos_d = end_pos;
          state_d = StFmt;
        end else begin
          rem_req.start    = 1'b1;
          rem_req.dividend = pos_mag;
          neg_d            = pos_q[SumW-1];
          state_d          = StMod;
        end
      end
      StMod: begin
        // floor modulo: a negative playhead wraps up from the top
        if (rem_done) begin
          if (neg_q && rem_val != '0) pos_d = $signed(SumW'(modulus - rem_val));
          else                        pos_d = $signed(SumW'(rem_val));
          state_d = StFmt;
        end
      end
      StFmt: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          frame_a_d   = fa[FrameW-1:0];
          frame_b_d   = fb[FrameW-1:0];
          blend_d     = to_q16(fr);
          oended_d    = ended_q;
          oplay_d     = flag_q;
          playhead_d  = pos_q[PheadW-1:0];
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      flag_q      <= 1'b0;
      ended_q     <= 1'b0;
      playhead_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      flag_q      <= flag_d;
      ended_q     <= ended_d;
      playhead_q  <= playhead_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    neg_q     <= neg_d;
    frame_a_q <= frame_a_d;
    frame_b_q <= frame_b_d;
    blend_q   <= blend_d;
    oended_q  <= oended_d;
    oplay_q   <= oplay_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.frame_a    = frame_a_q;
  assign out_o.frame_b    = frame_b_q;
  assign out_o.blend_t    = blend_q;
  assign out_o.ended      = oended_q;
  assign out_o.is_playing = oplay_q;

  // checks
  `KTS_ASSERT_IMP(a_ended_stops, out_o.valid && out_o.ended, !out_o.is_playing, "ended while playing")
  `KTS_ASSERT_IMP(a_rem_bound, rem_done, rem_val < modulus, "remainder not below modulus")
  `KTS_ASSERT_NXT(a_accept_busy, in_fire, state_q != StIdle, "accepted item not started")

endmodule

@@ sim/kts_frame_checker.sv @@
// Result checker for the keyframe timeline sequencer: tracks register writes,
// predicts one frame result per accepted command and compares the outputs.
// Depends on kts_pkg and the channel interfaces in kts_if.
`timescale 1ns / 1ps

module kts_frame_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  kts_in_if                            in_i,
  kts_out_if                           out_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [kts_pkg::CfgAddrW-1:0] paddr_i,
  input  logic [kts_pkg::CfgDataW-1:0] pwdata_i,
  input  logic                         pready_i,
  output int                           mismatches_o,
  output int                           pending_o,
  output int                           results_o,
  output int                           ends_o
);
  import kts_pkg::*;

  localparam int PrintCap = 20;

  typedef struct packed {
    logic [FrameW-1:0] frame_a;
    logic [FrameW-1:0] frame_b;
    logic [BlendW-1:0] blend_t;
    logic              ended;
    logic              is_playing;
  } frame_res_t;

  frame_res_t expected_frames[$];

  // shadow registers and timeline state
  logic [CountW-1:0] cfg_count;
  logic [FpsW-1:0]   cfg_fps;
  logic [ModeW-1:0]  cfg_mode;
  logic [RateW-1:0]  cfg_rate;
  logic [PheadW-1:0] playhead_q;
  logic              playing_q;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches_o < PrintCap) begin
      $display("%0t ns mismatch: %s got %0d expected %0d", $time, what, got, want);
    end
    mismatches_o++;
  endtask

  // apply one command to the timeline and work out its frame result
  function automatic frame_res_t advance_timeline(input func_e cmd,
                                                  input logic [DtW-1:0] dt,
                                                  input logic [SeekW-1:0] seek);
    longint count, one, last_pos, span, modulus, pos, rate, mag, step;
    longint whole, frac, fa, fb;
    logic ended;
    frame_res_t res;
    count = longint'(cfg_count);
    if (count < 1) count = 1;
    if (count > MaxFrames) count = MaxFrames;
    one = longint'(1) << FracBits;
    last_pos = (count - 1) * one;
    rate = longint'($signed(cfg_rate));
    pos = longint'(playhead_q);
    ended = 1'b0;

    case (cmd)
      FuncPlay:  playing_q = 1'b1;
      FuncPause: playing_q = 1'b0;
      FuncSeek:  pos = longint'(seek);
      default: begin
        if (playing_q) begin
          // dt * fps * |rate| is in 2^-40 frames
          mag = longint'(dt) * longint'(cfg_fps) * (rate < 0 ? -rate : rate);
          step = mag >> (40 - FracBits);
          pos += (rate < 0) ? -step : step;
          if (cfg_mode == ModeSingle && (pos < 0 || pos > last_pos)) begin
            pos = (rate < 0) ? 0 : last_pos;
            playing_q = 1'b0;
            ended = 1'b1;
          end
        end
      end
    endcase

    // normalize for the current mode
    if (cfg_mode == ModeSingle) begin
      if (pos < 0) pos = 0;
      if (pos > last_pos) pos = last_pos;
      whole = pos >> FracBits;
      frac = pos & (one - 1);
      fa = (whole < count - 1) ? whole : count - 1;
      fb = (fa + 1 < count - 1) ? fa + 1 : count - 1;
      if (fa == fb) frac = 0;
    end else begin
      span = (cfg_mode == ModeMirror) ? 2 * count : count;
      modulus = span * one;
      pos = pos % modulus;
      if (pos < 0) pos += modulus;
      whole = pos >> FracBits;
      frac = pos & (one - 1);
      fa = whole % span;
      fb = (fa + 1) % span;
      // fold the second half of the span back down
      if (cfg_mode == ModeMirror) begin
        if (fa >= count) fa = (count - 1) - (fa - count);
        if (fb >= count) fb = (count - 1) - (fb - count);
      end
    end

    playhead_q = PheadW'(pos);
    res.frame_a = FrameW'(fa);
    res.frame_b = FrameW'(fb);
    res.blend_t = BlendW'((frac << ShUp) >> ShDn);
    res.ended = ended;
    res.is_playing = playing_q;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_res_t want;
    if (!rst_ni) begin
      cfg_count = RstFrameCount;
      cfg_fps = RstFps;
      cfg_mode = RstPlayMode;
      cfg_rate = RstRate;
      playhead_q = '0;
      playing_q = 1'b0;
      expected_frames.delete();
      mismatches_o = 0;
      pending_o = 0;
      results_o = 0;
      ends_o = 0;
    end else begin
      // register write on the access phase
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[CfgAddrW-1:2])
          RegFrameCount: cfg_count = pwdata_i[CountW-1:0];
          RegFps:        cfg_fps = pwdata_i[FpsW-1:0];
          RegPlayMode:   cfg_mode = pwdata_i[ModeW-1:0];
          RegRate:       cfg_rate = pwdata_i[RateW-1:0];
          default: ;
        endcase
      end

      if (in_i.valid && in_i.ready) begin
        expected_frames.push_back(advance_timeline(func_e'(in_i.func), in_i.delta_time,
                                                   in_i.seek_position));
      end

      // compare each result transfer with the oldest prediction
      if (out_i.valid && out_i.ready) begin
        if (expected_frames.size() == 0) begin
          report_mismatch("result with nothing expected, frame_a", out_i.frame_a, -1);
        end else begin
          want = expected_frames.pop_front();
          results_o++;
          if (want.ended) ends_o++;
          if (out_i.frame_a !== want.frame_a)
            report_mismatch("frame_a", out_i.frame_a, want.frame_a);
          if (out_i.frame_b !== want.frame_b)
            report_mismatch("frame_b", out_i.frame_b, want.frame_b);
          if (out_i.blend_t !== want.blend_t)
            report_mismatch("blend_t", out_i.blend_t, want.blend_t);
          if (out_i.ended !== want.ended)
            report_mismatch("ended", out_i.ended, want.ended);
          if (out_i.is_playing !== want.is_playing)
            report_mismatch("is_playing", out_i.is_playing, want.is_playing);
        end
      end
      pending_o = expected_frames.size();
    end
  end

endmodule

@@ sim/tb.sv @@
// Top-level testbench for keyframe_timeline_sequencer_top: clock, reset,
// register writes over APB, command stimulus and result back-pressure.
// Depends on kts_pkg, kts_if and kts_frame_checker.
`timescale 1ns / 1ps

module tb;
  import kts_pkg::*;

  localparam int LimitCycles   = 400000;
  localparam int SettleCycles  = 80;
  localparam int HoldOffCycles = 400;
  localparam int HoldOffAfter  = 400;
  localparam int RandomItems   = 850;
  localparam int RandomPhases  = 10;

  localparam logic [ModeW-1:0] ModeSpare = 2'd3;
  localparam logic [RateW-1:0] RateMin   = 16'h8000;
  localparam logic [RateW-1:0] RateMax   = 16'h7FFF;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  int mismatches, pending, results, ends;
  int items_sent, settings, track_frames, burst_left;
  int cycles = 0;
  bit steady;

  kts_in_if  cmd_if ();
  kts_out_if frame_if ();

  keyframe_timeline_sequencer_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (cmd_if),
    .out_o   (frame_if)
  );

  kts_frame_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (cmd_if),
    .out_i        (frame_if),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .results_o    (results),
    .ends_o       (ends)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: random ready runs, stretches of steady ready, one long hold-off
  initial begin : result_sink
    int run_left;
    logic level;
    bit held_off;
    run_left = 0;
    level = 1'b0;
    held_off = 1'b0;
    frame_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held_off && items_sent >= HoldOffAfter) begin
        held_off = 1'b1;
        frame_if.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end
      if (run_left == 0) begin
        if ($urandom_range(0, 7) == 0) begin
          level = 1'b1;
          run_left = 60;
        end else begin
          level = ($urandom_range(0, 9) < 6);
          run_left = $urandom_range(1, 12);
        end
      end
      run_left--;
      frame_if.ready <= level;
    end
  end

  // one command transfer, then maybe a gap at the end of a burst
  task automatic push_cmd(input func_e f, input logic [DtW-1:0] dt,
                          input logic [SeekW-1:0] seek);
    cmd_if.valid <= 1'b1;
    cmd_if.func <= f;
    cmd_if.delta_time <= dt;
    cmd_if.seek_position <= seek;
    do @(posedge clk_i); while (!cmd_if.ready);
    items_sent++;
    if (!steady) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 15);
        cmd_if.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // setup and access phase, then idle with psel low before the next transfer
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CfgAddrW'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // write all four registers, junk above each field width
  task automatic set_track(input logic [CountW-1:0] c, input logic [FpsW-1:0] fr,
                           input logic [ModeW-1:0] m, input logic [RateW-1:0] r);
    write_reg(RegFrameCount, ($urandom << CountW) | CfgDataW'(c));
    write_reg(RegFps, ($urandom << FpsW) | CfgDataW'(fr));
    write_reg(RegPlayMode, ($urandom << ModeW) | CfgDataW'(m));
    write_reg(RegRate, ($urandom << RateW) | CfgDataW'(r));
    track_frames = (c == '0) ? 1 : (int'(c) > MaxFrames) ? MaxFrames : int'(c);
    settings++;
  endtask

  task automatic random_setting();
    logic [CountW-1:0] c;
    logic [FpsW-1:0] fr;
    logic [ModeW-1:0] m;
    logic [RateW-1:0] r;
    case ($urandom_range(0, 4))
      0: c = CountW'($urandom_range(1, 4));
      1: c = CountW'($urandom_range(1, 32));
      2: c = CountW'($urandom_range(1, MaxFrames));
      3: c = CountW'($urandom);
      default: c = CountW'(MaxFrames);
    endcase
    case ($urandom_range(0, 3))
      0: fr = RstFps;
      1: fr = FpsW'($urandom);
      2: fr = FpsW'($urandom_range(1, 2048));
      default: fr = '1;
    endcase
    case ($urandom_range(0, 9))
      0: m = ModeSpare;
      1, 2, 3: m = ModeSingle;
      4, 5, 6: m = ModeMirror;
      default: m = ModeLoop;
    endcase
    case ($urandom_range(0, 5))
      0: r = RstRate;
      1: r = -RstRate;
      2: r = RateMin;
      3: r = RateMax;
      4: r = RateW'($urandom_range(0, 16383) - 8192);
      default: r = RateW'($urandom);
    endcase
    set_track(c, fr, m, r);
  endtask

  // mostly ticks; seeks both within twice the track length and anywhere
  task automatic push_random();
    int pick;
    func_e f;
    logic [DtW-1:0] dt;
    logic [SeekW-1:0] seek;
    pick = $urandom_range(0, 99);
    f = (pick < 55) ? FuncTick : (pick < 70) ? FuncPlay : (pick < 80) ? FuncPause : FuncSeek;
    dt = DtW'($urandom) >> $urandom_range(0, DtW - 1);
    if ($urandom_range(0, 1) == 0) begin
      seek = SeekW'($urandom);
    end else begin
      seek = SeekW'(($urandom_range(0, 2 * track_frames) << FracBits) |
                    $urandom_range(0, (1 << FracBits) - 1));
    end
    push_cmd(f, dt, seek);
  endtask

  initial begin : stimulus
    int phase;
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cmd_if.valid <= 1'b0;
    cmd_if.func <= FuncTick;
    cmd_if.delta_time <= '0;
    cmd_if.seek_position <= '0;
    items_sent = 0;
    settings = 0;
    track_frames = 1;
    burst_left = 0;
    steady = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: single keyframe loop; paused tick, play, zero and max ticks, seek, pause
    push_cmd(FuncTick, '1, '0);
    push_cmd(FuncPlay, '0, '0);
    push_cmd(FuncTick, '0, '0);
    push_cmd(FuncTick, '1, '0);
    push_cmd(FuncSeek, '0, '1);
    push_cmd(FuncPause, '0, '0);
    drain_results();

    // full track, single shot, fastest forward: seek past the end, hit the end
    set_track(CountW'(MaxFrames), '1, ModeSingle, RateMax);
    push_cmd(FuncSeek, '0, SeekW'(((MaxFrames - 1) << FracBits) | 16'h8000));
    push_cmd(FuncSeek, '0, '0);
    push_cmd(FuncPlay, '0, '0);
    push_cmd(FuncTick, '1, '1);
    push_cmd(FuncTick, '1, '0);
    drain_results();

    // short track, single shot, fastest backward: hit frame zero
    set_track(CountW'(4), RstFps, ModeSingle, RateMin);
    push_cmd(FuncSeek, '0, SeekW'(2 << FracBits));
    push_cmd(FuncPlay, '0, '0);
    push_cmd(FuncTick, DtW'(1 << 20), '0);
    push_cmd(FuncTick, DtW'(1 << 20), '0);
    drain_results();

    // zero count, spare mode code, zero frame rate
    set_track('0, '0, ModeSpare, RstRate);
    push_cmd(FuncPlay, '0, '0);
    push_cmd(FuncTick, '1, '0);
    push_cmd(FuncSeek, '0, SeekW'(27'h12345));
    drain_results();

    // count above the limit, mirror, zero speed
    set_track('1, '1, ModeMirror, '0);
    push_cmd(FuncSeek, '0, '1);
    push_cmd(FuncSeek, '0, SeekW'((1500 << FracBits) | 16'hFFFF));
    push_cmd(FuncPlay, '0, '0);
    push_cmd(FuncTick, '1, '0);
    drain_results();

    // small mirror track, fold at the top of the span and wrap on a tick
    set_track(CountW'(3), RstFps, ModeMirror, RstRate);
    push_cmd(FuncSeek, '0, SeekW'((5 << FracBits) | 16'hFFFF));
    push_cmd(FuncPlay, '0, '0);
    push_cmd(FuncTick, DtW'(1 << 20), '0);
    push_cmd(FuncPause, '0, '0);
    drain_results();

    // random settings; one phase without sender gaps
    for (phase = 0; phase < RandomPhases; phase++) begin
      random_setting();
      steady = (phase == 3);
      repeat (RandomItems / RandomPhases) push_random();
      drain_results();
    end

    $display("Sent %0d commands over %0d register settings, with sender gaps, result stalls",
             items_sent, settings);
    $display("and one long result hold-off; %0d frame results checked, %0d single-shot ends",
             results, ends);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/kts_pkg.sv
hdl/kts_if.sv
hdl/kts_cfg.sv
hdl/kts_serial_mul.sv
hdl/kts_serial_rem.sv
hdl/keyframe_timeline_sequencer_top.sv
sim/kts_frame_checker.sv
sim/tb.sv
